>>> rtl/cfpd_pkg.sv
// cfpd_pkg: shared types and constants for the crlf framed pose deframer
// no dependencies; used by the channel interfaces, the parser and the top level

package cfpd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned FRAME_LEN  = 24;
	localparam int unsigned WORD_COUNT = 6;
	localparam int unsigned BYTES_PER_WORD = WORD_W / BYTE_W;
	localparam int unsigned IDX_W      = $clog2(FRAME_LEN + 1);

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	localparam byte_t MARK_CR = 8'h0D;
	localparam byte_t MARK_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_HUNT     = 3'd0,
		PH_HDR_LF   = 3'd1,
		PH_DATA     = 3'd2,
		PH_TRAIL_LF = 3'd3,
		PH_TRAIL_CR = 3'd4
	} phase_t;

	// parser status seen by the top level
	typedef struct packed {
		logic at_close;
		logic frame_done;
	} cfpd_stat_t;

endpackage

>>> rtl/cfpd_byte_if.sv
// cfpd_byte_if: valid/ready channel carrying one received serial byte
// depends on cfpd_pkg

interface cfpd_byte_if import cfpd_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/cfpd_pose_if.sv
// cfpd_pose_if: valid/ready channel carrying one decoded frame of six words
// depends on cfpd_pkg

interface cfpd_pose_if import cfpd_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t word0;
	word_t word1;
	word_t word2;
	word_t word3;
	word_t word4;
	word_t word5;

	modport source (output valid, output word0, output word1, output word2,
		output word3, output word4, output word5, input ready);
	modport sink   (input valid, input word0, input word1, input word2,
		input word3, input word4, input word5, output ready);
endinterface

>>> rtl/cfpd_parser.sv
// cfpd_parser: frame state machine and 24-byte payload store
// depends on cfpd_pkg

module cfpd_parser import cfpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  byte_t      data,
	output cfpd_stat_t stat,
	output word_t      words [WORD_COUNT]
);

	phase_t phase_q, phase_d;
	idx_t   idx_q, idx_d;
	idx_t   idx_eff;
	idx_t   idx_inc;
	byte_t  store_q [FRAME_LEN];

	assign idx_eff = (idx_q >= IDX_W'(FRAME_LEN)) ? '0 : idx_q;
	assign idx_inc = idx_eff + IDX_W'(1);

	// next state
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		case (phase_q)
			PH_HUNT: begin
				if (data == MARK_CR) phase_d = PH_HDR_LF;
			end
			PH_HDR_LF: begin
				if (data == MARK_LF) begin
					idx_d   = '0;
					phase_d = PH_DATA;
				end else if (data != MARK_CR) begin
					phase_d = PH_HUNT;
				end
			end
			PH_DATA: begin
				if (idx_inc >= IDX_W'(FRAME_LEN)) begin
					idx_d   = '0;
					phase_d = PH_TRAIL_LF;
				end else begin
					idx_d = idx_inc;
				end
			end
			PH_TRAIL_LF: begin
				phase_d = (data == MARK_LF) ? PH_TRAIL_CR : PH_HUNT;
			end
			PH_TRAIL_CR: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// outputs
	always_comb begin
		stat.at_close   = (phase_q == PH_TRAIL_CR);
		stat.frame_done = step && (phase_q == PH_TRAIL_CR) && (data == MARK_CR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && phase_q == PH_DATA) store_q[idx_eff] <= data;
	end

	// little-endian packing, byte 4k in bits 7:0
	for (genvar k = 0; k < WORD_COUNT; k++) begin : g_word
		for (genvar j = 0; j < BYTES_PER_WORD; j++) begin : g_byte
			assign words[k][j*BYTE_W +: BYTE_W] = store_q[k*BYTES_PER_WORD + j];
		end
	end

endmodule

>>> rtl/crlf_framed_pose_deframer.sv
// crlf_framed_pose_deframer: top level, input register, parser and result register
// depends on cfpd_pkg, cfpd_byte_if, cfpd_pose_if and cfpd_parser
//
// usage
//  rx carries one received serial byte per request (valid/ready)
//  frames look like 0x0D 0x0A, 24 payload bytes, 0x0A 0x0D; extra 0x0D bytes
//  are allowed before the header 0x0A, any other mismatch drops back to hunting
//  pose carries one request per good frame: six little-endian 32-bit words,
//  raw float bit patterns, word k from payload bytes 4k..4k+3
//  the closing 0x0D is held in the input register; when the parser steps on it, the result register is loaded
//  throughput: one byte per cycle while not stalled, set by the single parser step per byte
//  reset clears the input stage, the parser phase and the result valid;
//  the payload store is not cleared, every slot is written before any result
//  when pose is stalled the block keeps taking bytes; only a byte that arrives
//  at the close phase waits in the input register until the held result is taken

module crlf_framed_pose_deframer import cfpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	cfpd_byte_if.sink   rx,
	cfpd_pose_if.source pose
);

	// input register
	logic  valid_s1;
	byte_t byte_s1;

	// result register
	logic  out_valid_q;
	word_t word_q [WORD_COUNT];

	cfpd_stat_t stat;
	word_t      words [WORD_COUNT];
	logic       stall;
	logic       step;

	// a byte at the close phase needs a free result register
	assign stall    = valid_s1 && stat.at_close && out_valid_q && !pose.ready;
	assign step     = valid_s1 && !stall;
	assign rx.ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) byte_s1 <= rx.rx_byte;
	end

	cfpd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (byte_s1),
		.stat   (stat),
		.words  (words)
	);

	// frame_done only fires when the result register is free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.frame_done) begin
			out_valid_q <= 1'b1;
		end else if (pose.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.frame_done) word_q <= words;
	end

	assign pose.valid = out_valid_q;
	assign pose.word0 = word_q[0];
	assign pose.word1 = word_q[1];
	assign pose.word2 = word_q[2];
	assign pose.word3 = word_q[3];
	assign pose.word4 = word_q[4];
	assign pose.word5 = word_q[5];

endmodule

>>> bench/pose_frame_checker.sv
// pose_frame_checker: watches the byte and pose channels of the deframer,
// predicts each decoded frame and compares it word by word
// depends on cfpd_pkg

module pose_frame_checker import cfpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_ready,
	input  byte_t       rx_byte,
	input  logic        pose_valid,
	input  logic        pose_ready,
	input  word_t       word0,
	input  word_t       word1,
	input  word_t       word2,
	input  word_t       word3,
	input  word_t       word4,
	input  word_t       word5,
	output int unsigned fails,
	output int unsigned pending,
	output int unsigned checked
);

	typedef logic [WORD_COUNT-1:0][WORD_W-1:0] pose_t;

	phase_t      frame_phase;
	idx_t        slot;
	byte_t       payload [FRAME_LEN];
	pose_t       expected_poses [$];
	int unsigned fail_count  = 0;
	int unsigned check_count = 0;

	// word k takes payload bytes 4k..4k+3, lowest byte first
	function automatic pose_t pack_payload();
		pose_t p;
		for (int k = 0; k < WORD_COUNT; k++) begin
			p[k] = {payload[4*k+3], payload[4*k+2], payload[4*k+1], payload[4*k]};
		end
		return p;
	endfunction

	task automatic parse_rx_byte(input byte_t b);
		case (frame_phase)
			PH_HUNT: begin
				frame_phase = (b == MARK_CR) ? PH_HDR_LF : PH_HUNT;
			end
			PH_HDR_LF: begin
				// extra CR bytes keep waiting for the LF
				if (b == MARK_LF) begin
					slot        = '0;
					frame_phase = PH_DATA;
				end else if (b != MARK_CR) begin
					frame_phase = PH_HUNT;
				end
			end
			PH_DATA: begin
				if (slot >= FRAME_LEN) slot = '0;
				payload[slot] = b;
				slot = slot + 1'b1;
				if (slot >= FRAME_LEN) begin
					slot        = '0;
					frame_phase = PH_TRAIL_LF;
				end
			end
			PH_TRAIL_LF: begin
				frame_phase = (b == MARK_LF) ? PH_TRAIL_CR : PH_HUNT;
			end
			PH_TRAIL_CR: begin
				frame_phase = PH_HUNT;
				if (b == MARK_CR) expected_poses.push_back(pack_payload());
			end
			default: begin
				frame_phase = PH_HUNT;
			end
		endcase
	endtask

	task automatic compare_pose(input pose_t got);
		pose_t want;
		if (expected_poses.size() == 0) begin
			$error("pose request with no frame outstanding: word0 %h", got[0]);
			fail_count++;
		end else begin
			want = expected_poses.pop_front();
			check_count++;
			for (int k = 0; k < WORD_COUNT; k++) begin
				if (got[k] !== want[k]) begin
					$error("word%0d mismatch: expected %h, actual %h", k, want[k], got[k]);
					fail_count++;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_phase = PH_HUNT;
			slot        = '0;
			expected_poses.delete();
		end else begin
			if (rx_valid && rx_ready) parse_rx_byte(rx_byte);
			if (pose_valid && pose_ready)
				compare_pose({word5, word4, word3, word2, word1, word0});
		end
		fails   <= fail_count;
		pending <= expected_poses.size();
		checked <= check_count;
	end

endmodule

>>> bench/tb_top.sv
// tb_top: drives serial bytes into the deframer with random gaps and stalls
// depends on cfpd_pkg, the two channel interfaces, the deframer and pose_frame_checker

module tb_top;
	import cfpd_pkg::*;

	localparam int ITEMS     = 1950;
	localparam int HOLD_LEN  = 400;
	localparam int DRAIN_LEN = 20;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cfpd_byte_if rx_ch ();
	cfpd_pose_if pose_ch ();

	int unsigned fails;
	int unsigned pending;
	int unsigned checked;

	// stimulus bookkeeping for the summary; bytes_sent also bounds the random part
	int bytes_sent    = 0;
	int good_frames   = 0;
	int broken_frames = 0;
	int noise_runs    = 0;

	// sender side: number of back-to-back requests still owed
	int burst_left = 0;

	// set by the stimulus to ask the receiver for one long hold-off
	bit hold_go = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	crlf_framed_pose_deframer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.pose   (pose_ch)
	);

	pose_frame_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_ch.valid),
		.rx_ready   (rx_ch.ready),
		.rx_byte    (rx_ch.rx_byte),
		.pose_valid (pose_ch.valid),
		.pose_ready (pose_ch.ready),
		.word0      (pose_ch.word0),
		.word1      (pose_ch.word1),
		.word2      (pose_ch.word2),
		.word3      (pose_ch.word3),
		.word4      (pose_ch.word4),
		.word5      (pose_ch.word5),
		.fails      (fails),
		.pending    (pending),
		.checked    (checked)
	);

	// mostly no gap, sometimes a short one, rarely a long one;
	// now and then a long burst with no gaps at all
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst_left = $urandom_range(50, 150);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random byte that avoids the two given values
	function automatic byte_t other_byte(input byte_t a, input byte_t b);
		byte_t v;
		v = byte_t'($urandom_range(0, 255));
		while (v == a || v == b) v = byte_t'($urandom_range(0, 255));
		return v;
	endfunction

	// one request on rx; returns on the edge that takes it
	task automatic push_byte(input byte_t b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// CR, sometimes a few repeated CRs, then LF
	task automatic push_header();
		push_byte(MARK_CR);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) push_byte(MARK_CR);
		end
		push_byte(MARK_LF);
	endtask

	// payload bytes lean toward the marker values to stress the parser
	task automatic push_payload();
		int r;
		for (int i = 0; i < FRAME_LEN; i++) begin
			r = $urandom_range(0, 7);
			if (r == 0) push_byte(MARK_CR);
			else if (r == 1) push_byte(MARK_LF);
			else push_byte(byte_t'($urandom_range(0, 255)));
		end
	endtask

	// stop offering bytes until every predicted pose has come out
	task automatic pause_for_results();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// receiver: random ready pattern, plus one long hold-off on request
	initial begin
		bit hold_done;
		int run;
		int gap;
		int r;
		hold_done = 1'b0;
		pose_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_go && !hold_done) begin
				// block fills up and has to stall its input
				pose_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_done = 1'b1;
			end
			r = $urandom_range(0, 99);
			run = (r < 5) ? $urandom_range(100, 200) : $urandom_range(1, 30);
			pose_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			r = $urandom_range(0, 99);
			if (r < 40) gap = 0;
			else if (r < 92) gap = $urandom_range(1, 3);
			else gap = $urandom_range(15, 50);
			if (gap > 0) begin
				pose_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		byte_t corner_payload [FRAME_LEN];
		bit paused;
		int kind;
		corner_payload = '{8'h00, 8'hFF, 8'h0D, 8'h0A, 8'h0A, 8'h0D, 8'h80, 8'h7F,
			8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
			8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F};
		paused = 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header broken by a stray byte, then dropped back to hunting
		push_byte(MARK_CR);
		push_byte(8'h55);
		// repeated CRs before LF, payload with extremes and marker values
		push_byte(MARK_CR);
		push_byte(MARK_CR);
		push_byte(MARK_CR);
		push_byte(MARK_LF);
		for (int i = 0; i < FRAME_LEN; i++) push_byte(corner_payload[i]);
		push_byte(MARK_LF);
		push_byte(MARK_CR);
		good_frames++;
		broken_frames++;
		pause_for_results();

		// random part: mostly good frames, some broken ones and noise
		hold_go = 1'b1;
		while (bytes_sent < ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				push_header();
				push_payload();
				push_byte(MARK_LF);
				push_byte(MARK_CR);
				good_frames++;
			end else if (kind < 78) begin
				// bad byte after the header CR
				push_byte(MARK_CR);
				push_byte(other_byte(MARK_CR, MARK_LF));
				broken_frames++;
			end else if (kind < 84) begin
				// wrong trailer LF; a CR here must not start a new frame
				push_header();
				push_payload();
				push_byte($urandom_range(0, 1) ? MARK_CR : other_byte(MARK_LF, MARK_LF));
				broken_frames++;
			end else if (kind < 90) begin
				// wrong closing byte, no pose expected
				push_header();
				push_payload();
				push_byte(MARK_LF);
				push_byte($urandom_range(0, 1) ? MARK_LF : other_byte(MARK_CR, MARK_CR));
				broken_frames++;
			end else begin
				repeat ($urandom_range(1, 6)) push_byte(byte_t'($urandom_range(0, 255)));
				noise_runs++;
			end
			if (!paused && bytes_sent > ITEMS / 2) begin
				pause_for_results();
				paused = 1'b1;
			end
		end

		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_LEN) @(posedge clk);

		$display("sent %0d bytes: %0d well-formed frames, %0d broken frames, %0d noise runs",
			bytes_sent, good_frames, broken_frames, noise_runs);
		$display("compared %0d decoded poses word by word", checked);
		if (fails == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
